### hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure and temperature compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int RawWidth   = 20;
   localparam int TempWidth  = 27;
   localparam int PressWidth = 24;
   localparam int V1Width    = 33;
   localparam int OneShift   = 47;
   localparam int DivShift   = 33;
   localparam int DivBits    = 64;

   localparam logic [31:0]        TempRound = 32'd128;
   localparam logic [V1Width-1:0] TfOffset  = 33'd128000;
   localparam logic [20:0]        PFull     = 21'd1048576;
   localparam logic [11:0]        PScale    = 12'd3125;

   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_COEFFS = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_LOW   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_HIGH  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_NINE  = 3'd3;

   typedef struct packed {
      logic [RawWidth-1:0] raw_temp;
      logic [RawWidth-1:0] raw_press;
   } req_word_type;

   typedef struct packed {
      logic signed [TempWidth-1:0] temperature_centi;
      logic [PressWidth-1:0]       pressure_pa;
      logic                        pressure_invalid;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

endpackage

### hdl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer temperature and pressure compensation of raw sensor readings.
//
//   channel  ports                         direction  word
//   request  req_valid req_stall req_word  in         raw temperature, pressure
//   result   rsp_valid rsp_stall rsp_word  out        centi-degrees, pascals, flag
//   config   csr_valid csr_ready csr_index in         calibration coefficients
//            csr_wdata
//
// One word enters per cycle while the result is not stalled; the 66-stage
// divider (64 restoring steps plus input and output registers) sits after
// 10 polynomial stages and before 4 correction stages.
// Synchronous reset clears the stage valid bits and coefficients.
// A stalled result freezes every stage; the request side stalls with it.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation import ptc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_word,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [63:0]              csr_wdata
);

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff, press_high_ff;
   logic [15:0] press_nine_ff;
   coef_type coef;
   logic en;

   logic t_valid;
   logic signed [TempWidth-1:0] t_temp;
   logic signed [V1Width-1:0] t_v1;
   logic [RawWidth-1:0] t_raw_press;
   logic p_valid;
   logic signed [TempWidth-1:0] p_temp;
   logic [63:0] p_num, p_den;
   logic d_valid, d_invalid;
   logic signed [TempWidth-1:0] d_temp;
   logic [63:0] d_quo;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_nine_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata[47:0];
            CSR_PRESS_LOW:   press_low_ff   <= csr_wdata;
            CSR_PRESS_HIGH:  press_high_ff  <= csr_wdata;
            CSR_PRESS_NINE:  press_nine_ff  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      coef.t1 = temp_coeffs_ff[15:0];
      coef.t2 = temp_coeffs_ff[31:16];
      coef.t3 = temp_coeffs_ff[47:32];
      coef.p1 = press_low_ff[15:0];
      coef.p2 = press_low_ff[31:16];
      coef.p3 = press_low_ff[47:32];
      coef.p4 = press_low_ff[63:48];
      coef.p5 = press_high_ff[15:0];
      coef.p6 = press_high_ff[31:16];
      coef.p7 = press_high_ff[47:32];
      coef.p8 = press_high_ff[63:48];
      coef.p9 = press_nine_ff;
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   ptc_temp u_temp (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .in_word       (req_word),
      .coef          (coef),
      .out_valid     (t_valid),
      .out_temp      (t_temp),
      .out_v1        (t_v1),
      .out_raw_press (t_raw_press)
   );

   ptc_press u_press (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (t_valid),
      .in_temp      (t_temp),
      .in_v1        (t_v1),
      .in_raw_press (t_raw_press),
      .coef         (coef),
      .out_valid    (p_valid),
      .out_temp     (p_temp),
      .out_num      (p_num),
      .out_den      (p_den)
   );

   ptc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (p_valid),
      .in_temp     (p_temp),
      .in_num      (p_num),
      .in_den      (p_den),
      .out_valid   (d_valid),
      .out_temp    (d_temp),
      .out_quo     (d_quo),
      .out_invalid (d_invalid)
   );

   ptc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (d_valid),
      .in_temp    (d_temp),
      .in_quo     (d_quo),
      .in_invalid (d_invalid),
      .coef       (coef),
      .out_valid  (rsp_valid),
      .out_word   (rsp_word)
   );

endmodule

### hdl/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Fine temperature in 32-bit arithmetic, temperature output and pressure offset.
// ----------------------------------------------------------------------------
module ptc_temp import ptc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  req_word_type                in_word,
   input  coef_type                    coef,
   output logic                        out_valid,
   output logic signed [TempWidth-1:0] out_temp,
   output logic signed [V1Width-1:0]   out_v1,
   output logic [RawWidth-1:0]         out_raw_press
);

   logic [31:0] x, d, t2x, t3x;
   logic [31:0] aprod_in, aprod_ff, dsq_in, dsq_ff;
   logic [31:0] a32_in, a32_ff, bprod_in, bprod_ff;
   logic [31:0] fine_in, fine_ff, f5;
   logic signed [31:0] ash, dsh, bsh, tsh;
   logic signed [TempWidth-1:0] temp_in, temp_ff;
   logic signed [V1Width-1:0] v1_in, v1_ff;
   logic [V1Width-1:0] v1_back;
   logic [RawWidth-1:0] rp1_ff, rp2_ff, rp3_ff, rp4_ff;
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;

   assign t2x = {{16{coef.t2[15]}}, coef.t2};
   assign t3x = {{16{coef.t3[15]}}, coef.t3};
   assign x = {15'b0, in_word.raw_temp[19:3]} - {15'b0, coef.t1, 1'b0};
   assign d = {16'b0, in_word.raw_temp[19:4]} - {16'b0, coef.t1};
   assign aprod_in = x * t2x;
   assign dsq_in = d * d;

   assign ash = $signed(aprod_ff) >>> 11;
   assign a32_in = ash;
   assign dsh = $signed(dsq_ff) >>> 12;
   assign bprod_in = $unsigned(dsh) * t3x;

   assign bsh = $signed(bprod_ff) >>> 14;
   assign fine_in = a32_ff + $unsigned(bsh);

   assign f5 = fine_ff * 32'd5 + TempRound;
   assign tsh = $signed(f5) >>> 8;
   assign temp_in = tsh[TempWidth-1:0];
   assign v1_in = $signed({fine_ff[31], fine_ff} - TfOffset);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aprod_ff <= aprod_in;
         dsq_ff   <= dsq_in;
         rp1_ff   <= in_word.raw_press;
         a32_ff   <= a32_in;
         bprod_ff <= bprod_in;
         rp2_ff   <= rp1_ff;
         fine_ff  <= fine_in;
         rp3_ff   <= rp2_ff;
         temp_ff  <= temp_in;
         v1_ff    <= v1_in;
         rp4_ff   <= rp3_ff;
      end
   end

   assign out_valid     = vld4_ff;
   assign out_temp      = temp_ff;
   assign out_v1        = v1_ff;
   assign out_raw_press = rp4_ff;

   assign v1_back = v1_ff + TfOffset;

   a_v1_from_fine: assert property (@(posedge clock) disable iff (reset)
      vld4_ff |-> v1_back[32] == v1_back[31])
      else $error("pressure offset does not come from a 32-bit fine temperature");

endmodule

### hdl/ptc_press.sv
// ----------------------------------------------------------------------------
// ptc_press
// 64-bit pressure polynomial: dividend and divisor for the pressure division.
// ----------------------------------------------------------------------------
module ptc_press import ptc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [TempWidth-1:0] in_temp,
   input  logic signed [V1Width-1:0]   in_v1,
   input  logic [RawWidth-1:0]         in_raw_press,
   input  coef_type                    coef,
   output logic                        out_valid,
   output logic signed [TempWidth-1:0] out_temp,
   output logic [63:0]                 out_num,
   output logic [63:0]                 out_den
);

   logic signed [65:0] vsq_full;
   logic signed [48:0] v1p5_in, v1p5_ff, v1p2_in, v1p2_ff;
   logic signed [48:0] v1p5b_ff, v1p2b_ff;
   logic [63:0] vsq_ff;
   logic signed [79:0] v2a_full, v1a_full;
   logic [63:0] v2a_ff, v1a_ff;
   logic [63:0] v2_in, v2_ff, v1b_in, v1b_ff;
   logic signed [63:0] v1a_sh, prod_sh;
   logic [20:0] p0;
   logic [63:0] m_in, m_ff, numa_in, numa_ff;
   logic signed [80:0] mp_full;
   logic [63:0] prod_ff, num_in, num_ff, num2_ff, den_ff;
   logic [RawWidth-1:0] rp5_ff, rp6_ff, rp7_ff;
   logic signed [TempWidth-1:0] tp5_ff, tp6_ff, tp7_ff, tp8_ff, tp9_ff, tp10_ff;
   logic vld5_ff, vld6_ff, vld7_ff, vld8_ff, vld9_ff, vld10_ff;

   assign vsq_full = in_v1 * in_v1;
   assign v1p5_in  = in_v1 * coef.p5;
   assign v1p2_in  = in_v1 * coef.p2;

   assign v2a_full = $signed(vsq_ff) * coef.p6;
   assign v1a_full = $signed(vsq_ff) * coef.p3;

   assign v1a_sh = $signed(v1a_ff) >>> 8;
   assign v2_in  = v2a_ff + (64'(v1p5b_ff) << 17) + (64'(coef.p4) << 35);
   assign v1b_in = $unsigned(v1a_sh) + (64'(v1p2b_ff) << 12);

   assign p0      = PFull - {1'b0, rp7_ff};
   assign m_in    = (64'd1 << OneShift) + v1b_ff;
   assign numa_in = ({43'b0, p0} << 31) - v2_ff;

   assign mp_full = $signed(m_ff) * $signed({1'b0, coef.p1});
   assign num_in  = numa_ff * {52'b0, PScale};

   assign prod_sh = $signed(prod_ff) >>> DivShift;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff  <= 1'b0;
         vld6_ff  <= 1'b0;
         vld7_ff  <= 1'b0;
         vld8_ff  <= 1'b0;
         vld9_ff  <= 1'b0;
         vld10_ff <= 1'b0;
      end else if (en) begin
         vld5_ff  <= in_valid;
         vld6_ff  <= vld5_ff;
         vld7_ff  <= vld6_ff;
         vld8_ff  <= vld7_ff;
         vld9_ff  <= vld8_ff;
         vld10_ff <= vld9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vsq_ff   <= vsq_full[63:0];
         v1p5_ff  <= v1p5_in;
         v1p2_ff  <= v1p2_in;
         rp5_ff   <= in_raw_press;
         tp5_ff   <= in_temp;
         v2a_ff   <= v2a_full[63:0];
         v1a_ff   <= v1a_full[63:0];
         v1p5b_ff <= v1p5_ff;
         v1p2b_ff <= v1p2_ff;
         rp6_ff   <= rp5_ff;
         tp6_ff   <= tp5_ff;
         v2_ff    <= v2_in;
         v1b_ff   <= v1b_in;
         rp7_ff   <= rp6_ff;
         tp7_ff   <= tp6_ff;
         m_ff     <= m_in;
         numa_ff  <= numa_in;
         tp8_ff   <= tp7_ff;
         prod_ff  <= mp_full[63:0];
         num_ff   <= num_in;
         tp9_ff   <= tp8_ff;
         den_ff   <= prod_sh;
         num2_ff  <= num_ff;
         tp10_ff  <= tp9_ff;
      end
   end

   assign out_valid = vld10_ff;
   assign out_temp  = tp10_ff;
   assign out_num   = num2_ff;
   assign out_den   = den_ff;

endmodule

### hdl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed 64-bit division, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module ptc_div import ptc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [TempWidth-1:0] in_temp,
   input  logic [63:0]                 in_num,
   input  logic [63:0]                 in_den,
   output logic                        out_valid,
   output logic signed [TempWidth-1:0] out_temp,
   output logic [63:0]                 out_quo,
   output logic                        out_invalid
);

   logic [DivBits:0] vld_ff, neg_ff, zero_ff;
   logic [63:0] rem_ff [0:DivBits];
   logic [63:0] nq_ff  [0:DivBits];
   logic [63:0] md_ff  [0:DivBits];
   logic signed [TempWidth-1:0] tmp_ff [0:DivBits];
   logic [63:0] mn, md, quo_in, quo_ff;
   logic vldo_ff, invo_ff;
   logic signed [TempWidth-1:0] tmpo_ff;

   assign mn = in_num[63] ? 64'd0 - in_num : in_num;
   assign md = in_den[63] ? 64'd0 - in_den : in_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= 64'd0;
         nq_ff[0]   <= mn;
         md_ff[0]   <= md;
         neg_ff[0]  <= in_num[63] ^ in_den[63];
         zero_ff[0] <= (in_den == 64'd0);
         tmp_ff[0]  <= in_temp;
      end
   end

   for (genvar k = 0; k < DivBits; k++) begin : g_step
      logic [63:0] trial;
      logic        ge;

      assign trial = {rem_ff[k][62:0], nq_ff[k][63]};
      assign ge    = (trial >= md_ff[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? trial - md_ff[k] : trial;
            nq_ff[k+1]   <= {nq_ff[k][62:0], ge};
            md_ff[k+1]   <= md_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            tmp_ff[k+1]  <= tmp_ff[k];
         end
      end
   end

   always_comb begin
      if (zero_ff[DivBits]) begin
         quo_in = 64'd0;
      end else if (neg_ff[DivBits]) begin
         quo_in = 64'd0 - nq_ff[DivBits];
      end else begin
         quo_in = nq_ff[DivBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldo_ff <= 1'b0;
      end else if (en) begin
         vldo_ff <= vld_ff[DivBits];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff  <= quo_in;
         invo_ff <= zero_ff[DivBits];
         tmpo_ff <= tmp_ff[DivBits];
      end
   end

   assign out_valid   = vldo_ff;
   assign out_quo     = quo_ff;
   assign out_invalid = invo_ff;
   assign out_temp    = tmpo_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DivBits] && !zero_ff[DivBits] |-> rem_ff[DivBits] < md_ff[DivBits])
      else $error("division remainder not below divisor");

endmodule

### hdl/ptc_post.sv
// ----------------------------------------------------------------------------
// ptc_post
// Second-order pressure correction and result word register.
// ----------------------------------------------------------------------------
module ptc_post import ptc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [TempWidth-1:0] in_temp,
   input  logic [63:0]                 in_quo,
   input  logic                        in_invalid,
   input  coef_type                    coef,
   output logic                        out_valid,
   output rsp_word_type                out_word
);

   logic signed [63:0] s;
   logic [31:0] s_lo, s_hi, lh_in, lh_ff;
   logic [63:0] ll_in, ll_ff;
   logic signed [79:0] fprod_full, eprod_full;
   logic [63:0] fprod_ff, sq_in, sq_ff, f_in, f_ff, fc_ff, eprod_ff;
   logic signed [63:0] fsh, esh, psh;
   logic [63:0] pa_ff, pb_ff, pc_ff, sum, pres;
   logic ia_ff, ib_ff, ic_ff;
   logic signed [TempWidth-1:0] ta_ff, tb_ff, tc_ff;
   logic vlda_ff, vldb_ff, vldc_ff, vldo_ff;
   rsp_word_type word_in, word_ff;

   assign s     = $signed(in_quo) >>> 13;
   assign s_lo  = s[31:0];
   assign s_hi  = s[63:32];
   assign ll_in = {32'b0, s_lo} * {32'b0, s_lo};
   assign lh_in = s_lo * s_hi;
   assign fprod_full = $signed(in_quo) * coef.p8;

   assign sq_in = ll_ff + {lh_ff[30:0], 33'b0};
   assign fsh   = $signed(fprod_ff) >>> 19;
   assign f_in  = fsh;

   assign eprod_full = $signed(sq_ff) * coef.p9;

   assign esh  = $signed(eprod_ff) >>> 25;
   assign sum  = pc_ff + $unsigned(esh) + fc_ff;
   assign psh  = $signed(sum) >>> 8;
   assign pres = $unsigned(psh) + (64'(coef.p7) << 4);

   always_comb begin
      word_in.temperature_centi = tc_ff;
      word_in.pressure_invalid  = ic_ff;
      word_in.pressure_pa       = ic_ff ? '0 : pres[31:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff <= 1'b0;
         vldb_ff <= 1'b0;
         vldc_ff <= 1'b0;
         vldo_ff <= 1'b0;
      end else if (en) begin
         vlda_ff <= in_valid;
         vldb_ff <= vlda_ff;
         vldc_ff <= vldb_ff;
         vldo_ff <= vldc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         fprod_ff <= fprod_full[63:0];
         pa_ff    <= in_quo;
         ia_ff    <= in_invalid;
         ta_ff    <= in_temp;
         sq_ff    <= sq_in;
         f_ff     <= f_in;
         pb_ff    <= pa_ff;
         ib_ff    <= ia_ff;
         tb_ff    <= ta_ff;
         eprod_ff <= eprod_full[63:0];
         fc_ff    <= f_ff;
         pc_ff    <= pb_ff;
         ic_ff    <= ib_ff;
         tc_ff    <= tb_ff;
         word_ff  <= word_in;
      end
   end

   assign out_valid = vldo_ff;
   assign out_word  = word_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      vldo_ff && word_ff.pressure_invalid |-> word_ff.pressure_pa == '0)
      else $error("invalid pressure word carries nonzero pressure");

endmodule

### tb/tb_pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation
// Self-checking bench for the compensation pipeline: calibration sets are
// loaded through the csr port, raw readings are pushed with random stalls on
// both sides, and every result word is compared with an integer predictor.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation;
   import ptc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrIndexWidth-1:0] CsrUnused = 3'd7;

   class comp_scoreboard;
      logic [47:0] temp_coeffs;
      logic [63:0] press_low;
      logic [63:0] press_high;
      logic [15:0] press_nine;
      rsp_word_type pending_q[$];
      int errors;
      int checked;
      int invalid_seen;

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [63:0] data);
         case (idx)
            CSR_TEMP_COEFFS: temp_coeffs = data[47:0];
            CSR_PRESS_LOW:   press_low   = data;
            CSR_PRESS_HIGH:  press_high  = data;
            CSR_PRESS_NINE:  press_nine  = data[15:0];
            default: ;
         endcase
      endfunction

      function rsp_word_type compensate(req_word_type w);
         logic [31:0] adc_t, t1, t2, t3, a32, b32, d, fine, tmp;
         logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic signed [63:0] v1, v2, p, e, f, s, num;
         rsp_word_type r;
         adc_t = {12'd0, w.raw_temp};
         t1 = {16'd0, temp_coeffs[15:0]};
         t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
         t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
         p1 = {48'd0, press_low[15:0]};
         p2 = {{48{press_low[31]}}, press_low[31:16]};
         p3 = {{48{press_low[47]}}, press_low[47:32]};
         p4 = {{48{press_low[63]}}, press_low[63:48]};
         p5 = {{48{press_high[15]}}, press_high[15:0]};
         p6 = {{48{press_high[31]}}, press_high[31:16]};
         p7 = {{48{press_high[47]}}, press_high[47:32]};
         p8 = {{48{press_high[63]}}, press_high[63:48]};
         p9 = {{48{press_nine[15]}}, press_nine};
         a32 = $signed(((adc_t >> 3) - (t1 << 1)) * t2) >>> 11;
         d = (adc_t >> 4) - t1;
         b32 = $signed(d * d) >>> 12;
         b32 = $signed(b32 * t3) >>> 14;
         fine = a32 + b32;
         tmp = $signed(fine * 32'd5 + 32'd128) >>> 8;
         r.temperature_centi = tmp[26:0];
         v1 = {{32{fine[31]}}, fine};
         v1 = v1 - 64'sd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) <<< 17);
         v2 = v2 + (p4 <<< 35);
         v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
         v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
         if (v1 == 0) begin
            r.pressure_pa = '0;
            r.pressure_invalid = 1'b1;
         end else begin
            p = 64'sd1048576 - {44'd0, w.raw_press};
            num = ((p <<< 31) - v2) * 64'sd3125;
            if (num == 64'sh8000000000000000 && v1 == -64'sd1) p = num;
            else p = num / v1;
            s = p >>> 13;
            e = (p9 * s * s) >>> 25;
            f = (p8 * p) >>> 19;
            p = ((p + e + f) >>> 8) + (p7 <<< 4);
            r.pressure_pa = p[31:8];
            r.pressure_invalid = 1'b0;
         end
         return r;
      endfunction

      function void note_reading(req_word_type w);
         pending_q.push_back(compensate(w));
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_w = pending_q.pop_front();
         checked++;
         if (got.pressure_invalid) invalid_seen++;
         if (got.temperature_centi !== exp_w.temperature_centi) begin
            $display("%0t: temperature expected %h actual %h", $time,
                     exp_w.temperature_centi, got.temperature_centi);
            errors++;
         end
         if (got.pressure_pa !== exp_w.pressure_pa) begin
            $display("%0t: pressure expected %h actual %h", $time,
                     exp_w.pressure_pa, got.pressure_pa);
            errors++;
         end
         if (got.pressure_invalid !== exp_w.pressure_invalid) begin
            $display("%0t: invalid flag expected %b actual %b", $time,
                     exp_w.pressure_invalid, got.pressure_invalid);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   comp_scoreboard sb = new();
   bit calm_tail = 0;
   bit hold_off = 0;
   int sets_loaded = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pressure_temperature_compensation u_dut (.*);

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_reading(req_word);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
   end

   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 0;
         end
         if (!calm_tail && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic load_coeffs(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                              logic [15:0] p9);
      write_csr(CSR_TEMP_COEFFS, {16'hdead, tc});
      write_csr(CSR_PRESS_LOW, pl);
      write_csr(CSR_PRESS_HIGH, ph);
      write_csr(CSR_PRESS_NINE, {48'hbeef_0000_0000, p9});
      write_csr(CsrUnused, 64'($urandom()));
      sets_loaded++;
   endtask

   task automatic send_reading(logic [19:0] t, logic [19:0] p);
      int n;
      if (!calm_tail && $urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{raw_temp: t, raw_press: p};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [15:0] near(int base, int spread);
      return 16'(base + $urandom_range(0, 2 * spread) - spread);
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // all-zero coefficients: divisor zero
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hfffff, 20'hfffff);
      drain();
      load_coeffs({16'h8000, 16'h8000, 16'hffff}, {16'h8000, 16'h8000, 16'h8000, 16'hffff},
                  {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
      send_reading(20'h00000, 20'hfffff);
      send_reading(20'hfffff, 20'h00000);
      send_reading(20'h80000, 20'h80000);
      drain();
      load_coeffs({16'h7fff, 16'h7fff, 16'h0000}, {16'h7fff, 16'h7fff, 16'h7fff, 16'h0000},
                  {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 16'h7fff);
      send_reading(20'hfffff, 20'hfffff);
      send_reading(20'h00000, 20'h00000);
      send_reading(20'h55555, 20'haaaaa);
      drain();
      load_coeffs({16'd64, 16'd26435, 16'd27504}, {16'd2855, -16'sd10685, 16'd3024,
                  16'd36477}, {16'd7, -16'sd7, 16'd15500, -16'sd14600}, 16'd6000);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'haaaaa, 20'h55555);
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 250; i++) begin
            if (k == 1 && i == 50) hold_off = 1;
            if (k == 3 && i == 170) calm_tail = 1;
            if ($urandom_range(0, 3) == 0)
               send_reading(20'($urandom()), 20'($urandom()));
            else
               send_reading(20'(20'd400000 + $urandom_range(0, 250000)),
                            20'(20'd250000 + $urandom_range(0, 400000)));
         end
         drain();
         if (k == 0)
            load_coeffs(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, 16'($urandom()));
         else
            load_coeffs({near(27504, 2000), near(26435, 2000), near(6000, 500)},
                        {near(2855, 200), near(-10685, 500), near(3024, 300),
                         near(36477, 2000)},
                        {near(-14600, 300), near(15500, 300), near(-7, 5), near(140, 60)},
                        near(6000, 500));
      end
      $display("Checked %0d results over %0d coefficient sets, %0d with zero divisor.",
               sb.checked, sets_loaded + 1, sb.invalid_seen);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
